// ----- sv/kuznyechik_block_cipher_unit_macros.svh -----
// Assertion macros shared by the cipher unit RTL.
`ifndef KUZNYECHIK_BLOCK_CIPHER_UNIT_MACROS_SVH
`define KUZNYECHIK_BLOCK_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define KBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define KBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define KBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/kbc_pkg.sv -----
// Types, tables and transform functions of the Kuznyechik cipher unit.
package kbc_pkg;

    localparam int NUM_ROUNDS  = 10;
    localparam int BLOCK_BYTES = 16;
    localparam int HALF_STEPS  = 8;
    localparam int KEY_WORDS   = 4;
    localparam int NUM_STAGES  = 2 * (NUM_ROUNDS - 1) + 1;

    typedef logic [8*BLOCK_BYTES-1:0] t_blk;
    typedef logic [63:0]              t_word;
    typedef logic [$clog2(KEY_WORDS)-1:0] t_kidx;
    typedef logic [7:0]               t_sbox [256];
    typedef t_blk                     t_keys [NUM_ROUNDS];

    localparam logic ACT_ENC = 1'b0;
    localparam logic ACT_DEC = 1'b1;

    localparam t_sbox SBOX = '{
        8'd252, 8'd238, 8'd221, 8'd17, 8'd207, 8'd110, 8'd49, 8'd22,
        8'd251, 8'd196, 8'd250, 8'd218, 8'd35, 8'd197, 8'd4, 8'd77,
        8'd233, 8'd119, 8'd240, 8'd219, 8'd147, 8'd46, 8'd153, 8'd186,
        8'd23, 8'd54, 8'd241, 8'd187, 8'd20, 8'd205, 8'd95, 8'd193,
        8'd249, 8'd24, 8'd101, 8'd90, 8'd226, 8'd92, 8'd239, 8'd33,
        8'd129, 8'd28, 8'd60, 8'd66, 8'd139, 8'd1, 8'd142, 8'd79,
        8'd5, 8'd132, 8'd2, 8'd174, 8'd227, 8'd106, 8'd143, 8'd160,
        8'd6, 8'd11, 8'd237, 8'd152, 8'd127, 8'd212, 8'd211, 8'd31,
        8'd235, 8'd52, 8'd44, 8'd81, 8'd234, 8'd200, 8'd72, 8'd171,
        8'd242, 8'd42, 8'd104, 8'd162, 8'd253, 8'd58, 8'd206, 8'd204,
        8'd181, 8'd112, 8'd14, 8'd86, 8'd8, 8'd12, 8'd118, 8'd18,
        8'd191, 8'd114, 8'd19, 8'd71, 8'd156, 8'd183, 8'd93, 8'd135,
        8'd21, 8'd161, 8'd150, 8'd41, 8'd16, 8'd123, 8'd154, 8'd199,
        8'd243, 8'd145, 8'd120, 8'd111, 8'd157, 8'd158, 8'd178, 8'd177,
        8'd50, 8'd117, 8'd25, 8'd61, 8'd255, 8'd53, 8'd138, 8'd126,
        8'd109, 8'd84, 8'd198, 8'd128, 8'd195, 8'd189, 8'd13, 8'd87,
        8'd223, 8'd245, 8'd36, 8'd169, 8'd62, 8'd168, 8'd67, 8'd201,
        8'd215, 8'd121, 8'd214, 8'd246, 8'd124, 8'd34, 8'd185, 8'd3,
        8'd224, 8'd15, 8'd236, 8'd222, 8'd122, 8'd148, 8'd176, 8'd188,
        8'd220, 8'd232, 8'd40, 8'd80, 8'd78, 8'd51, 8'd10, 8'd74,
        8'd167, 8'd151, 8'd96, 8'd115, 8'd30, 8'd0, 8'd98, 8'd68,
        8'd26, 8'd184, 8'd56, 8'd130, 8'd100, 8'd159, 8'd38, 8'd65,
        8'd173, 8'd69, 8'd70, 8'd146, 8'd39, 8'd94, 8'd85, 8'd47,
        8'd140, 8'd163, 8'd165, 8'd125, 8'd105, 8'd213, 8'd149, 8'd59,
        8'd7, 8'd88, 8'd179, 8'd64, 8'd134, 8'd172, 8'd29, 8'd247,
        8'd48, 8'd55, 8'd107, 8'd228, 8'd136, 8'd217, 8'd231, 8'd137,
        8'd225, 8'd27, 8'd131, 8'd73, 8'd76, 8'd63, 8'd248, 8'd254,
        8'd141, 8'd83, 8'd170, 8'd144, 8'd202, 8'd216, 8'd133, 8'd97,
        8'd32, 8'd113, 8'd103, 8'd164, 8'd45, 8'd43, 8'd9, 8'd91,
        8'd203, 8'd155, 8'd37, 8'd208, 8'd190, 8'd229, 8'd108, 8'd82,
        8'd89, 8'd166, 8'd116, 8'd210, 8'd230, 8'd244, 8'd180, 8'd192,
        8'd209, 8'd102, 8'd175, 8'd194, 8'd57, 8'd75, 8'd99, 8'd182
    };

    localparam logic [7:0] LIN_COEF [BLOCK_BYTES] = '{
        8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1, 8'd251,
        8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148, 8'd1
    };

    function automatic t_sbox make_sbox_inv();
        t_sbox r;
        for (int i = 0; i < 256; i++) begin
            r[SBOX[i]] = 8'(i);
        end
        return r;
    endfunction

    localparam t_sbox SBOX_INV = make_sbox_inv();

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [8:0] x;
        logic [7:0] y;
        logic [7:0] r;
        r = 8'd0;
        x = {1'b0, a};
        y = b;
        for (int k = 0; k < 8; k++) begin
            if (y[0]) r = r ^ x[7:0];
            y = y >> 1;
            x = x << 1;
            if (x[8]) x = x ^ 9'h1C3;
        end
        return r;
    endfunction

    function automatic logic [7:0] lin_sum(t_blk b);
        logic [7:0] acc;
        acc = 8'd0;
        for (int j = 0; j < BLOCK_BYTES; j++) begin
            acc = acc ^ gf_mul(b[8*j +: 8], LIN_COEF[j]);
        end
        return acc;
    endfunction

    function automatic t_blk lfwd_step(t_blk b);
        return {b[8*BLOCK_BYTES-9:0], lin_sum(b)};
    endfunction

    function automatic t_blk linv_step(t_blk b);
        t_blk t;
        t = {b[7:0], b[8*BLOCK_BYTES-1:8]};
        return {lin_sum(t), t[8*BLOCK_BYTES-9:0]};
    endfunction

    // half of the linear layer: eight shift-register steps
    function automatic t_blk lfwd_half(t_blk b);
        t_blk t;
        t = b;
        for (int k = 0; k < HALF_STEPS; k++) t = lfwd_step(t);
        return t;
    endfunction

    function automatic t_blk linv_half(t_blk b);
        t_blk t;
        t = b;
        for (int k = 0; k < HALF_STEPS; k++) t = linv_step(t);
        return t;
    endfunction

    function automatic t_blk lfwd_full(t_blk b);
        return lfwd_half(lfwd_half(b));
    endfunction

    function automatic t_blk sub_fwd(t_blk b);
        t_blk o;
        for (int j = 0; j < BLOCK_BYTES; j++) o[8*j +: 8] = SBOX[b[8*j +: 8]];
        return o;
    endfunction

    function automatic t_blk sub_inv(t_blk b);
        t_blk o;
        for (int j = 0; j < BLOCK_BYTES; j++) o[8*j +: 8] = SBOX_INV[b[8*j +: 8]];
        return o;
    endfunction

    // L of a block whose last byte is 2^n; the key constants are XORs of these
    localparam t_blk CBASE [6] = '{
        lfwd_full(t_blk'(1) << 120), lfwd_full(t_blk'(1) << 121),
        lfwd_full(t_blk'(1) << 122), lfwd_full(t_blk'(1) << 123),
        lfwd_full(t_blk'(1) << 124), lfwd_full(t_blk'(1) << 125)
    };

    function automatic t_blk step_const(logic [5:0] n);
        t_blk c;
        c = '0;
        for (int b = 0; b < 6; b++) begin
            if (n[b]) c = c ^ CBASE[b];
        end
        return c;
    endfunction

endpackage

// ----- sv/kbc_in_if.sv -----
// Input item channel: action and one 128-bit block.
interface kbc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [63:0] block_low;
    logic [63:0] block_high;

    modport source (output valid, action, block_low, block_high, input ready);
    modport sink (input valid, action, block_low, block_high, output ready);
endinterface

// ----- sv/kbc_out_if.sv -----
// Result item channel: one 128-bit block.
interface kbc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;

    modport source (output valid, result_low, result_high, input ready);
    modport sink (input valid, result_low, result_high, output ready);
endinterface

// ----- sv/kbc_cfg_if.sv -----
// Configuration write channel: key word index and data.
interface kbc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/kuznyechik_block_cipher_unit.sv -----
// Top level of the pipelined Kuznyechik encrypt/decrypt unit.
// Usage:
//  - i_cfg writes key word 0..3 (index, 64-bit data). Each write re-expands the
//    full 256-bit key; i_cfg.ready and i_in.ready stay low while the ten
//    round keys and their inverse-linear copies are built.
//  - i_in carries one 16-byte block and the action bit (0 encrypt, 1 decrypt);
//    byte 0 sits in block_low[7:0].
//  - o_out returns the result block, same byte order.
//  - Each round is split over two register stages (S box plus the first half
//    of the linear layer, then its second half), plus a final key-add stage:
//    19 stages, one item per cycle unless o_out stalls or keys are expanding.
//  - A stalled receiver holds the last stage; upstream stages keep filling
//    empty slots and stop only when the next stage is full. Nothing is lost or
//    repeated.
//  - Reset clears pipeline valids and the key words; round keys hold no value
//    until the first key write.
`include "kuznyechik_block_cipher_unit_macros.svh"
module kuznyechik_block_cipher_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kbc_cfg_if.sink  i_cfg,
    kbc_in_if.sink   i_in,
    kbc_out_if.source o_out
);
    import kbc_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    t_keys  w_rk;
    t_keys  w_irk;
    logic   w_busy;

    logic   r_v [NUM_STAGES];
    logic   r_a [NUM_STAGES];
    t_blk   r_d [NUM_STAGES];
    t_blk   n_d [NUM_STAGES];
    logic   w_en [NUM_STAGES+1];
    t_blk   w_src [NUM_ROUNDS-1];
    logic   w_acc;

    kbc_key_sched u_key_sched (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_rk    (w_rk),
        .o_irk   (w_irk),
        .o_busy  (w_busy)
    );

    // a stage takes new data when empty or when the next one moves
    always_comb begin
        w_en[NUM_STAGES] = o_out.ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0] && !w_busy;
    assign w_acc      = i_in.valid && i_in.ready;

    for (genvar g = 0; g < NUM_ROUNDS - 1; g++) begin : g_round
        if (g == 0) begin : g_first
            assign w_src[g] = {i_in.block_high, i_in.block_low};
            assign n_d[0] = (i_in.action == ACT_DEC) ? linv_half(w_src[g])
                          : lfwd_half(sub_fwd(w_src[g] ^ w_rk[g]));
        end else begin : g_rest
            assign w_src[g] = r_d[2*g-1];
            assign n_d[2*g] = (r_a[2*g-1] == ACT_DEC) ? linv_half(sub_inv(w_src[g]))
                            : lfwd_half(sub_fwd(w_src[g] ^ w_rk[g]));
        end
        assign n_d[2*g+1] = (r_a[2*g] == ACT_DEC)
                          ? (linv_half(r_d[2*g]) ^ w_irk[NUM_ROUNDS-1-g])
                          : lfwd_half(r_d[2*g]);
    end

    assign n_d[LAST] = (r_a[LAST-1] == ACT_DEC) ? (sub_inv(r_d[LAST-1]) ^ w_rk[0])
                     : (r_d[LAST-1] ^ w_rk[NUM_ROUNDS-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STAGES; k++) r_v[k] <= 1'b0;
        end else begin
            if (w_en[0]) r_v[0] <= w_acc;
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_d[0] <= n_d[0];
            r_a[0] <= i_in.action;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_d[k] <= n_d[k];
                r_a[k] <= r_a[k-1];
            end
        end
    end

    assign o_out.valid       = r_v[LAST];
    assign o_out.result_low  = r_d[LAST][63:0];
    assign o_out.result_high = r_d[LAST][127:64];

    `KBC_ASSERT(a_no_acc_busy, i_clk, i_rst_n, !(w_acc && w_busy), "item accepted during key expansion")
    `KBC_ASSERT_NEXT(a_acc_enters, i_clk, i_rst_n, w_acc, r_v[0], "accepted item missing from first stage")
    `KBC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_v[LAST] && !o_out.ready, r_v[LAST] && $stable(r_d[LAST]), "stalled result changed")
endmodule

// ----- sv/kbc_key_sched.sv -----
// Key store and iterative round key expansion with inverse-linear copies.
`include "kuznyechik_block_cipher_unit_macros.svh"
module kbc_key_sched (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kbc_cfg_if.sink       i_cfg,
    output kbc_pkg::t_keys o_rk,
    output kbc_pkg::t_keys o_irk,
    output logic          o_busy
);
    import kbc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOAD, S_EXPAND, S_INVERT} t_state;

    t_state      r_state;
    t_word       r_kw [KEY_WORDS];
    t_blk        r_rk [NUM_ROUNDS];
    t_blk        r_irk [NUM_ROUNDS];
    t_blk        r_a1;
    t_blk        r_a0;
    t_blk        r_t;
    logic [4:0]  r_cnt;
    logic        r_ph;

    logic        w_wr;
    t_blk        w_half;
    t_blk        w_f;
    t_blk        w_ih;
    t_blk        w_ih2;
    logic [3:0]  w_ki;

    assign w_wr   = i_cfg.valid && i_cfg.ready;
    assign w_half = lfwd_half(sub_fwd(r_a1 ^ step_const({1'b0, r_cnt} + 6'd1)));
    assign w_f    = lfwd_half(r_t) ^ r_a0;
    assign w_ih   = linv_half(r_rk[r_cnt[3:0]]);
    assign w_ih2  = linv_half(r_t);
    assign w_ki   = {1'b0, r_cnt[4:3], 1'b0} + 4'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            for (int i = 0; i < KEY_WORDS; i++) r_kw[i] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_wr) begin
                        r_kw[i_cfg.index] <= i_cfg.data;
                        r_state           <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_rk[0] <= {r_kw[1], r_kw[0]};
                    r_rk[1] <= {r_kw[3], r_kw[2]};
                    r_a1    <= {r_kw[1], r_kw[0]};
                    r_a0    <= {r_kw[3], r_kw[2]};
                    r_cnt   <= '0;
                    r_ph    <= 1'b0;
                    r_state <= S_EXPAND;
                end
                S_EXPAND: begin
                    if (!r_ph) begin
                        r_t  <= w_half;
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        r_a0 <= r_a1;
                        r_a1 <= w_f;
                        // every eighth step yields the next pair of round keys
                        if (r_cnt[2:0] == 3'd7) begin
                            r_rk[w_ki]        <= w_f;
                            r_rk[w_ki + 4'd1] <= r_a1;
                        end
                        if (r_cnt == 5'd31) begin
                            r_cnt   <= '0;
                            r_state <= S_INVERT;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                S_INVERT: begin
                    if (!r_ph) begin
                        r_t  <= w_ih;
                        r_ph <= 1'b1;
                    end else begin
                        r_irk[r_cnt[3:0]] <= w_ih2;
                        r_ph              <= 1'b0;
                        if (r_cnt == 5'(NUM_ROUNDS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + 5'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_cfg.ready = (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_rk        = r_rk;
    assign o_irk       = r_irk;

    `KBC_ASSERT_NEXT(a_wr_starts, i_clk, i_rst_n, w_wr, r_state == S_LOAD, "key write did not start expansion")
    `KBC_ASSERT(a_no_wr_busy, i_clk, i_rst_n, !(o_busy && i_cfg.ready), "config ready while expanding")
    `KBC_ASSERT_NEXT(a_exp_done, i_clk, i_rst_n, r_state == S_EXPAND && r_ph && r_cnt == 5'd31, r_state == S_INVERT, "expansion did not hand over to inversion")
endmodule
